// File: rtl/rpo_pkg.sv
// Shared types, register codes and constants for the RGB point operation unit.
`timescale 1ns / 1ps

package rpo_pkg;

    // Channel and fixed-point widths.
    localparam int CH_W      = 8;
    localparam int Q_SHIFT   = 6;
    localparam int NUM_CH    = 3;
    localparam int SUM_W     = 10;
    localparam int OPND_W    = CH_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int CTR_W     = PROD_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Divide by three as a multiply by 683 / 2048, exact for sums below 2048.
    localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
    localparam int               DIV3_SHIFT = 11;

    // Register reset values.
    localparam logic [CH_W-1:0] RST_CHANNEL_GAIN   = 8'd96;
    localparam logic [CH_W-1:0] RST_CONTRAST_GAIN  = 8'd80;
    localparam logic [CH_W-1:0] RST_CONTRAST_PIVOT = 8'd128;
    localparam logic [CH_W-1:0] RST_MONO_THRESHOLD = 8'd128;

    // Operating modes.
    typedef enum logic [2:0] {
        MODE_PASS     = 3'd0,
        MODE_GREY     = 3'd1,
        MODE_MONO     = 3'd2,
        MODE_NEGATIVE = 3'd3,
        MODE_GAIN     = 3'd4,
        MODE_CONTRAST = 3'd5
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_CHANNEL_SELECT = 3'd1,
        REG_CHANNEL_GAIN   = 3'd2,
        REG_CONTRAST_GAIN  = 3'd3,
        REG_CONTRAST_PIVOT = 3'd4,
        REG_MONO_THRESHOLD = 3'd5
    } t_reg_idx;

    // Configuration register file contents.
    typedef struct packed {
        logic [2:0]      mode;
        logic [1:0]      channel_select;
        logic [CH_W-1:0] channel_gain;
        logic [CH_W-1:0] contrast_gain;
        logic [CH_W-1:0] contrast_pivot;
        logic [CH_W-1:0] mono_threshold;
    } t_cfg;

    // Input word.
    typedef struct packed {
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] red_in;
        logic            end_of_image;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
        logic            end_of_image_out;
    } t_out_word;

endpackage

// File: rtl/rpo_cfg_regs.sv
// Configuration register file of the RGB point operation unit.
`timescale 1ns / 1ps

module rpo_cfg_regs
    import rpo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; indexes past the last register are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MODE:           n_cfg.mode           = i_cfg_data[2:0];
                REG_CHANNEL_SELECT: n_cfg.channel_select = i_cfg_data[1:0];
                REG_CHANNEL_GAIN:   n_cfg.channel_gain   = i_cfg_data[CH_W-1:0];
                REG_CONTRAST_GAIN:  n_cfg.contrast_gain  = i_cfg_data[CH_W-1:0];
                REG_CONTRAST_PIVOT: n_cfg.contrast_pivot = i_cfg_data[CH_W-1:0];
                REG_MONO_THRESHOLD: n_cfg.mono_threshold = i_cfg_data[CH_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= MODE_PASS;
            r_cfg.channel_select <= 2'd0;
            r_cfg.channel_gain   <= RST_CHANNEL_GAIN;
            r_cfg.contrast_gain  <= RST_CONTRAST_GAIN;
            r_cfg.contrast_pivot <= RST_CONTRAST_PIVOT;
            r_cfg.mono_threshold <= RST_MONO_THRESHOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/rgb_point_operation_unit.sv
// Top level of the RGB point operation unit: a three-stage pixel pipeline.
`timescale 1ns / 1ps

// One BGR pixel word enters per clock and one processed word leaves per
// clock while the output side does not stall. The three register stages
// are: operand setup (channel sum, offset from the contrast pivot), the
// multipliers (divide-by-three reciprocal and one 9x9 signed multiply per
// channel), and clamping plus the mode select, which loads the output
// register. Each stage holds a valid bit and moves on whenever the stage
// after it is empty or moving, so a stall at the output backs up through
// the stages without losing or repeating a word, and bubbles are squeezed
// out. Configuration registers must be written only while the pipeline is
// empty.
module rgb_point_operation_unit
    import rpo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    input  t_in_word             i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_out_word            o_data,
    input  logic                 i_stall
);

    t_cfg w_cfg;

    rpo_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    t_mode w_mode;
    assign w_mode = t_mode'(w_cfg.mode);

    // Stage valid bits and the ready chain.
    logic r_vld1, r_vld2, r_vld3;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3  = !r_vld3 || !i_stall;
    assign w_rdy2  = !r_vld2 || w_rdy3;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_vld1 <= i_valid;
            end
            if (w_rdy2) begin
                r_vld2 <= r_vld1;
            end
            if (w_rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    // Stage 1: channel sum and multiplier operands.
    logic [CH_W-1:0]          w_in_ch [NUM_CH];
    logic signed [OPND_W-1:0] w_opnd  [NUM_CH];
    logic [SUM_W-1:0]         w_sum;

    assign w_in_ch[0] = i_data.blue_in;
    assign w_in_ch[1] = i_data.green_in;
    assign w_in_ch[2] = i_data.red_in;

    assign w_sum = {2'b00, i_data.blue_in} + {2'b00, i_data.green_in}
                 + {2'b00, i_data.red_in};

    t_in_word                 r1_pix;
    logic [SUM_W-1:0]         r1_sum;
    logic signed [OPND_W-1:0] r1_opnd [NUM_CH];

    for (genvar c = 0; c < NUM_CH; c++) begin : g_opnd
        // Contrast scales the offset from the pivot; gain scales the level.
        assign w_opnd[c] = (w_mode == MODE_CONTRAST)
                         ? $signed({1'b0, w_in_ch[c]}) - $signed({1'b0, w_cfg.contrast_pivot})
                         : $signed({1'b0, w_in_ch[c]});
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_pix  <= i_data;
            r1_sum  <= w_sum;
            r1_opnd <= w_opnd;
        end
    end

    // Stage 2: average by reciprocal multiply and per-channel products.
    logic [2*SUM_W-1:0]       w_avg_prod;
    logic signed [OPND_W-1:0] w_factor;
    logic signed [PROD_W-1:0] w_prod [NUM_CH];

    assign w_avg_prod = {{SUM_W{1'b0}}, r1_sum} * {{SUM_W{1'b0}}, DIV3_MUL};
    assign w_factor   = (w_mode == MODE_CONTRAST)
                      ? $signed({1'b0, w_cfg.contrast_gain})
                      : $signed({1'b0, w_cfg.channel_gain});

    for (genvar c = 0; c < NUM_CH; c++) begin : g_mul
        assign w_prod[c] = PROD_W'(r1_opnd[c]) * PROD_W'(w_factor);
    end

    t_in_word                 r2_pix;
    logic [CH_W-1:0]          r2_avg;
    logic signed [PROD_W-1:0] r2_prod [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_pix  <= r1_pix;
            r2_avg  <= w_avg_prod[DIV3_SHIFT+CH_W-1:DIV3_SHIFT];
            r2_prod <= w_prod;
        end
    end

    // Stage 3: clamp, select by mode, load the output register.
    logic [CH_W-1:0]         w_ch2   [NUM_CH];
    logic [CH_W-1:0]         w_gain  [NUM_CH];
    logic [CH_W-1:0]         w_ctr   [NUM_CH];
    logic [CH_W-1:0]         w_res   [NUM_CH];
    logic signed [CTR_W-1:0] w_t     [NUM_CH];
    logic [CH_W-1:0]         w_mono;

    assign w_ch2[0] = r2_pix.blue_in;
    assign w_ch2[1] = r2_pix.green_in;
    assign w_ch2[2] = r2_pix.red_in;

    assign w_mono = (r2_avg >= w_cfg.mono_threshold) ? CH_MAX : '0;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_out
        // Gain product is never negative; saturate after the Q2.6 shift.
        assign w_gain[c] = (r2_prod[c][PROD_W-2:Q_SHIFT+CH_W] != '0)
                         ? CH_MAX : r2_prod[c][Q_SHIFT+CH_W-1:Q_SHIFT];

        // Contrast: add back the pivot in Q6, clamp to the channel range.
        assign w_t[c] = CTR_W'(r2_prod[c])
                      + $signed({{(CTR_W-CH_W-Q_SHIFT){1'b0}}, w_cfg.contrast_pivot,
                                 {Q_SHIFT{1'b0}}});
        assign w_ctr[c] = w_t[c][CTR_W-1] ? '0
                        : (w_t[c][CTR_W-2:Q_SHIFT+CH_W] != '0)
                          ? CH_MAX : w_t[c][Q_SHIFT+CH_W-1:Q_SHIFT];

        always_comb begin
            case (w_mode)
                MODE_GREY:     w_res[c] = r2_avg;
                MODE_MONO:     w_res[c] = w_mono;
                MODE_NEGATIVE: w_res[c] = CH_MAX - w_ch2[c];
                MODE_GAIN:     w_res[c] = (w_cfg.channel_select == 2'(c))
                                        ? w_gain[c] : w_ch2[c];
                MODE_CONTRAST: w_res[c] = w_ctr[c];
                default:       w_res[c] = w_ch2[c];
            endcase
        end
    end

    t_out_word r3_out;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_out.blue_out         <= w_res[0];
            r3_out.green_out        <= w_res[1];
            r3_out.red_out          <= w_res[2];
            r3_out.end_of_image_out <= r2_pix.end_of_image;
        end
    end

    assign o_valid = r_vld3;
    assign o_data  = r3_out;

endmodule

// File: rtl/rpo_checker.sv
// Port-level checks of the RGB point operation unit and their binding.
`timescale 1ns / 1ps

module rpo_checker
    import rpo_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      o_stall,
    input  logic      o_valid,
    input  t_out_word o_data,
    input  logic      i_stall
);

    // A word held at the output stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // With nothing at the output every stage can move, so input never stalls.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // A word taken in reaches the output if the output does not stall while it moves through the stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted word did not reach the output");

endmodule

bind rgb_point_operation_unit rpo_checker u_rpo_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
